### design/websocket_frame_deframer_top_macros.svh
// assertion macros for the websocket frame deframer
`ifndef WEBSOCKET_FRAME_DEFRAMER_TOP_MACROS_SVH
`define WEBSOCKET_FRAME_DEFRAMER_TOP_MACROS_SVH

// same-cycle implication, disabled during reset
`define WSFD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled during reset
`define WSFD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### design/wsfd_pkg.sv
// shared types and constants for the websocket frame deframer
package wsfd_pkg;

	// result codes
	localparam logic [2:0] RC_PAYLOAD = 3'd0;
	localparam logic [2:0] RC_EMPTY   = 3'd1;
	localparam logic [2:0] RC_PROTO   = 3'd2;
	localparam logic [2:0] RC_BADLEN  = 3'd3;
	localparam logic [2:0] RC_REJECT  = 3'd4;

	// configuration register indexes
	localparam logic CFG_ROLE    = 1'b0;
	localparam logic CFG_MAX_LEN = 1'b1;

	// opcode of a close frame
	localparam logic [3:0] OPC_CLOSE = 4'h8;

	// reset value of the frame length limit (10 MiB)
	localparam logic [31:0] MAX_LEN_RESET = 32'd10485760;

	// one result item
	typedef struct packed {
		logic [2:0]  code;
		logic [7:0]  payload_byte;
		logic        last_of_frame;
		logic        fin_bit;
		logic [2:0]  rsv_bits;
		logic [3:0]  frame_opcode;
		logic [31:0] frame_length;
		logic        connection_closed;
	} wsfd_result_t;

endpackage

### design/wsfd_parse_core.sv
// frame header parser and payload unmasker, one byte per step
module wsfd_parse_core import wsfd_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         step,
	input  logic         kind,
	input  logic [7:0]   data_byte,
	input  logic         role_is_client,
	input  logic [31:0]  max_frame_length,
	output logic         res_valid,
	output wsfd_result_t res
);

	// parse phases
	localparam logic [2:0] PH_HDR1    = 3'd0;
	localparam logic [2:0] PH_HDR2    = 3'd1;
	localparam logic [2:0] PH_EXT16   = 3'd2;
	localparam logic [2:0] PH_EXT64   = 3'd3;
	localparam logic [2:0] PH_MASK    = 3'd4;
	localparam logic [2:0] PH_DATA    = 3'd5;
	localparam logic [2:0] PH_BLOCKED = 3'd6;

	logic [2:0]  phase_q, phase_d;
	logic        fin_q, fin_d;
	logic [2:0]  rsv_q, rsv_d;
	logic [3:0]  opc_q, opc_d;
	logic        masked_q, masked_d;
	logic [63:0] acc_q, acc_d;
	logic [3:0]  hcnt_q, hcnt_d;
	logic [31:0] key_q, key_d;
	logic [31:0] total_q, total_d;
	logic [31:0] count_q, count_d;

	// next state and result for the byte in hand
	always_comb begin
		logic        emit;
		logic        reject;
		logic        do_clear;
		logic        do_block;
		logic        known;
		logic        empty;
		logic [31:0] len;
		logic [7:0]  key_byte;
		logic [7:0]  pbyte;
		logic        last;
		logic        closed;
		logic [2:0]  code;

		phase_d  = phase_q;
		fin_d    = fin_q;
		rsv_d    = rsv_q;
		opc_d    = opc_q;
		masked_d = masked_q;
		acc_d    = acc_q;
		hcnt_d   = hcnt_q;
		key_d    = key_q;
		total_d  = total_q;
		count_d  = count_q;
		emit     = 1'b0;
		reject   = 1'b0;
		do_clear = 1'b0;
		do_block = 1'b0;
		known    = 1'b0;
		empty    = 1'b0;
		len      = '0;
		key_byte = '0;
		pbyte    = '0;
		last     = 1'b0;
		closed   = 1'b0;
		code     = RC_PAYLOAD;

		if (kind) begin
			do_clear = 1'b1;
		end else begin
			case (phase_q)
				PH_HDR1: begin
					fin_d = data_byte[7];
					rsv_d = data_byte[6:4];
					opc_d = data_byte[3:0];
					// fragmented control frame
					if (!data_byte[7] && data_byte[3]) begin
						emit     = 1'b1;
						code     = RC_PROTO;
						do_block = 1'b1;
					end else begin
						phase_d = PH_HDR2;
					end
				end
				PH_HDR2: begin
					masked_d = data_byte[7];
					acc_d    = '0;
					hcnt_d   = '0;
					total_d  = '0;
					count_d  = '0;
					key_d    = '0;
					if (opc_q[3] && (data_byte[6:0] > 7'd125)) begin
						emit     = 1'b1;
						code     = RC_PROTO;
						do_block = 1'b1;
					end else if (data_byte[6:0] == 7'd126) begin
						phase_d = PH_EXT16;
					end else if (data_byte[6:0] == 7'd127) begin
						phase_d = PH_EXT64;
					end else begin
						known = 1'b1;
						len   = {25'd0, data_byte[6:0]};
					end
				end
				PH_EXT16: begin
					acc_d  = {48'd0, acc_q[7:0], data_byte};
					hcnt_d = hcnt_q + 4'd1;
					if (hcnt_d >= 4'd2) begin
						if (acc_d[15:0] < 16'd126) begin
							emit     = 1'b1;
							code     = RC_BADLEN;
							do_block = 1'b1;
						end else begin
							known = 1'b1;
							len   = {16'd0, acc_d[15:0]};
						end
					end
				end
				PH_EXT64: begin
					acc_d  = {acc_q[55:0], data_byte};
					hcnt_d = hcnt_q + 4'd1;
					if (hcnt_d >= 4'd8) begin
						// top bit set, or above the limit on all 64 bits
						if (acc_d[63] || (acc_d[63:32] != 32'd0) ||
								(acc_d[31:0] > max_frame_length)) begin
							emit     = 1'b1;
							code     = RC_BADLEN;
							do_block = 1'b1;
						end else begin
							known = 1'b1;
							len   = acc_d[31:0];
						end
					end
				end
				PH_MASK: begin
					key_d  = {key_q[23:0], data_byte};
					hcnt_d = hcnt_q + 4'd1;
					if (hcnt_d >= 4'd4) begin
						hcnt_d = '0;
						if (total_q == 32'd0) begin
							empty = 1'b1;
						end else begin
							phase_d = PH_DATA;
						end
					end
				end
				PH_DATA: begin
					// key byte chosen by payload position, first key byte on top
					case (count_q[1:0])
						2'd0:    key_byte = key_q[31:24];
						2'd1:    key_byte = key_q[23:16];
						2'd2:    key_byte = key_q[15:8];
						default: key_byte = key_q[7:0];
					endcase
					pbyte   = masked_q ? (data_byte ^ key_byte) : data_byte;
					count_d = count_q + 32'd1;
					emit    = 1'b1;
					code    = RC_PAYLOAD;
					if (count_d >= total_q) begin
						last   = 1'b1;
						closed = (opc_q == OPC_CLOSE);
						if (closed) begin
							do_block = 1'b1;
						end else begin
							do_clear = 1'b1;
						end
					end
				end
				default: begin
					emit     = 1'b1;
					reject   = 1'b1;
					code     = RC_REJECT;
					do_block = 1'b1;
				end
			endcase

			// length settled: mask rule, then payload, key or empty frame
			if (known) begin
				total_d = len;
				hcnt_d  = '0;
				if (masked_d) begin
					if (role_is_client) begin
						emit     = 1'b1;
						code     = RC_PROTO;
						do_block = 1'b1;
					end else begin
						phase_d = PH_MASK;
					end
				end else if (!role_is_client && (len != 32'd0)) begin
					emit     = 1'b1;
					code     = RC_PROTO;
					do_block = 1'b1;
				end else if (len == 32'd0) begin
					empty = 1'b1;
				end else begin
					phase_d = PH_DATA;
				end
			end

			// frame with no payload is complete
			if (empty) begin
				emit   = 1'b1;
				code   = RC_EMPTY;
				closed = (opc_d == OPC_CLOSE);
				if (closed) begin
					do_block = 1'b1;
				end else begin
					do_clear = 1'b1;
				end
			end
		end

		// result fields taken before any clearing
		res_valid             = emit;
		res.code              = code;
		res.payload_byte      = pbyte;
		res.last_of_frame     = last;
		res.fin_bit           = reject ? 1'b0 : fin_d;
		res.rsv_bits          = reject ? 3'd0 : rsv_d;
		res.frame_opcode      = reject ? 4'd0 : opc_d;
		res.frame_length      = reject ? 32'd0 : total_d;
		res.connection_closed = closed;

		if (do_block) begin
			phase_d = PH_BLOCKED;
		end
		if (do_clear) begin
			phase_d  = PH_HDR1;
			fin_d    = 1'b0;
			rsv_d    = '0;
			opc_d    = '0;
			masked_d = 1'b0;
			acc_d    = '0;
			hcnt_d   = '0;
			key_d    = '0;
			total_d  = '0;
			count_d  = '0;
		end
	end

	// parse state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HDR1;
			fin_q    <= 1'b0;
			rsv_q    <= '0;
			opc_q    <= '0;
			masked_q <= 1'b0;
			acc_q    <= '0;
			hcnt_q   <= '0;
			key_q    <= '0;
			total_q  <= '0;
			count_q  <= '0;
		end else if (step) begin
			phase_q  <= phase_d;
			fin_q    <= fin_d;
			rsv_q    <= rsv_d;
			opc_q    <= opc_d;
			masked_q <= masked_d;
			acc_q    <= acc_d;
			hcnt_q   <= hcnt_d;
			key_q    <= key_d;
			total_q  <= total_d;
			count_q  <= count_d;
		end
	end

endmodule

### design/websocket_frame_deframer_top.sv
// websocket frame deframer top level
//
//  channel  direction  handshake               payload
//  item     in         item_valid/item_stall   kind, data_byte
//  result   out        result_valid/result_stall  result_code .. connection_closed
//  cfg      in         cfg_valid/cfg_ready     cfg_index, cfg_data
//
// one byte a cycle sustained while the result is not stalled; an item transfer reaches
// the result through the input register, then parser logic into the result register
// the parse state is updated once per byte, so the parser loop sets the rate
// reset returns parsing to the first header byte, server role, 10 MiB limit
// a held result stalls the input register; bytes giving no result still wait
// cfg_ready is always high
`include "websocket_frame_deframer_top_macros.svh"

module websocket_frame_deframer_top import wsfd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	// input items
	input  logic        item_valid,
	output logic        item_stall,
	input  logic        kind,
	input  logic [7:0]  data_byte,
	// result items
	output logic        result_valid,
	input  logic        result_stall,
	output logic [2:0]  result_code,
	output logic [7:0]  payload_byte,
	output logic        last_of_frame,
	output logic        fin_bit,
	output logic [2:0]  rsv_bits,
	output logic [3:0]  frame_opcode,
	output logic [31:0] frame_length,
	output logic        connection_closed,
	// configuration writes
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [31:0] cfg_data
);

	logic         role_q;
	logic [31:0]  max_len_q;
	logic         item_valid_s1;
	logic         kind_s1;
	logic [7:0]   byte_s1;
	logic         advance;
	logic         step;
	logic         core_valid;
	wsfd_result_t core_res;
	logic         result_valid_q;
	wsfd_result_t result_q;

	// configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			role_q    <= 1'b0;
			max_len_q <= MAX_LEN_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_ROLE:    role_q    <= cfg_data[0];
				CFG_MAX_LEN: max_len_q <= cfg_data;
				default:     role_q    <= role_q;
			endcase
		end
	end

	// pipeline moves when the result register is free or being emptied
	assign advance    = !result_valid_q || !result_stall;
	assign step       = item_valid_s1 && advance;
	assign item_stall = item_valid_s1 && !advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid_s1 <= 1'b0;
		end else if (item_valid && !item_stall) begin
			item_valid_s1 <= 1'b1;
		end else if (step) begin
			item_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			kind_s1 <= kind;
			byte_s1 <= data_byte;
		end
	end

	// parser
	wsfd_parse_core u_core (
		.clk              (clk),
		.arst_n           (arst_n),
		.step             (step),
		.kind             (kind_s1),
		.data_byte        (byte_s1),
		.role_is_client   (role_q),
		.max_frame_length (max_len_q),
		.res_valid        (core_valid),
		.res              (core_res)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (advance) begin
			result_valid_q <= step && core_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (step && core_valid) begin
			result_q <= core_res;
		end
	end

	assign result_valid      = result_valid_q;
	assign result_code       = result_q.code;
	assign payload_byte      = result_q.payload_byte;
	assign last_of_frame     = result_q.last_of_frame;
	assign fin_bit           = result_q.fin_bit;
	assign rsv_bits          = result_q.rsv_bits;
	assign frame_opcode      = result_q.frame_opcode;
	assign frame_length      = result_q.frame_length;
	assign connection_closed = result_q.connection_closed;

	// checks
	`WSFD_ASSERT_NOW(a_last_on_payload, clk, arst_n, result_valid_q && result_q.last_of_frame, result_q.code == RC_PAYLOAD, "last_of_frame on a non-payload result")
	`WSFD_ASSERT_NOW(a_closed_on_close, clk, arst_n, result_valid_q && result_q.connection_closed, (result_q.frame_opcode == OPC_CLOSE) && (result_q.code == RC_EMPTY || (result_q.code == RC_PAYLOAD && result_q.last_of_frame)), "close flagged outside a completed close frame")
	`WSFD_ASSERT_NOW(a_stall_cause, clk, arst_n, item_stall, item_valid_s1 && result_valid_q && result_stall, "input stalled without a blocked result")
	`WSFD_ASSERT_NEXT(a_item_held, clk, arst_n, item_valid && !item_stall, item_valid_s1, "transferred item missing from input register")

endmodule

### tb/sv/testbench.sv
// testbench for the websocket frame deframer: byte stream driven in, results checked per transfer
`timescale 1ns / 100ps

module testbench import wsfd_pkg::*; ();

	// item kinds
	localparam logic KIND_DATA    = 1'b0;
	localparam logic KIND_RESTART = 1'b1;

	// opcodes used by the stimulus
	localparam logic [3:0] OPC_CONT   = 4'h0;
	localparam logic [3:0] OPC_TEXT   = 4'h1;
	localparam logic [3:0] OPC_BINARY = 4'h2;
	localparam logic [3:0] OPC_PING   = 4'h9;
	localparam logic [3:0] OPC_PONG   = 4'hA;

	// length encoding
	localparam logic [6:0]  LEN16_MARK      = 7'd126;
	localparam logic [6:0]  LEN64_MARK      = 7'd127;
	localparam logic [6:0]  MAX_CONTROL_LEN = 7'd125;
	localparam logic [63:0] MIN_LEN16       = 64'd126;

	localparam int unsigned NO_CAP     = 32'hFFFF_FFFF;
	localparam int unsigned PIPE_SLACK = 4;

	typedef enum logic [2:0] {
		PH_HEAD1, PH_HEAD2, PH_LEN16, PH_LEN64, PH_KEY, PH_BODY, PH_HALTED
	} parse_phase_t;

	typedef enum logic [1:0] {FORM_SHORT, FORM_16, FORM_64} length_form_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        item_valid = 1'b0;
	logic        item_stall;
	logic        kind = KIND_DATA;
	logic [7:0]  data_byte = 8'h00;
	logic        result_valid;
	logic        result_stall = 1'b0;
	logic [2:0]  result_code;
	logic [7:0]  payload_byte;
	logic        last_of_frame;
	logic        fin_bit;
	logic [2:0]  rsv_bits;
	logic [3:0]  frame_opcode;
	logic [31:0] frame_length;
	logic        connection_closed;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic        cfg_index = CFG_ROLE;
	logic [31:0] cfg_data = 32'd0;

	websocket_frame_deframer_top DUT (
		.clk, .arst_n,
		.item_valid, .item_stall, .kind, .data_byte,
		.result_valid, .result_stall, .result_code, .payload_byte, .last_of_frame,
		.fin_bit, .rsv_bits, .frame_opcode, .frame_length, .connection_closed,
		.cfg_valid, .cfg_ready, .cfg_index, .cfg_data
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// deframer state as predicted by the testbench
	logic         client_role = 1'b0;
	logic [31:0]  len_limit = MAX_LEN_RESET;
	parse_phase_t phase = PH_HEAD1;
	logic         fin_q = 1'b0;
	logic [2:0]   rsv_q = 3'd0;
	logic [3:0]   opc_q = 4'd0;
	logic         masked_q = 1'b0;
	logic [6:0]   short_q = 7'd0;
	logic [63:0]  ext_q = 64'd0;
	logic [3:0]   hcount = 4'd0;
	logic [31:0]  key_q = 32'd0;
	logic [31:0]  total_q = 32'd0;
	logic [31:0]  count_q = 32'd0;

	wsfd_result_t results_due[$];
	int unsigned  mismatches = 0;
	int unsigned  items_sent = 0;
	bit           gap_enable = 1'b0;
	bit           stall_enable = 1'b0;
	int unsigned  stall_left = 0;

	function automatic void clear_frame_state();
		phase = PH_HEAD1;
		fin_q = 1'b0; rsv_q = 3'd0; opc_q = 4'd0; masked_q = 1'b0;
		short_q = 7'd0; ext_q = 64'd0; hcount = 4'd0;
		key_q = 32'd0; total_q = 32'd0; count_q = 32'd0;
	endfunction

	function automatic void post_result(input logic [2:0] code, input logic [7:0] pb,
			input logic last, input logic closed);
		wsfd_result_t r;
		r.code = code;
		r.payload_byte = pb;
		r.last_of_frame = last;
		r.fin_bit = fin_q;
		r.rsv_bits = rsv_q;
		r.frame_opcode = opc_q;
		r.frame_length = total_q;
		r.connection_closed = closed;
		results_due.push_back(r);
	endfunction

	function automatic void halt_with(input logic [2:0] code);
		phase = PH_HALTED;
		post_result(code, 8'd0, 1'b0, 1'b0);
	endfunction

	// frame without payload is complete; a close frame halts the decoder
	function automatic void finish_empty_frame();
		logic closed;
		closed = (opc_q == OPC_CLOSE);
		post_result(RC_EMPTY, 8'd0, 1'b0, closed);
		if (closed) phase = PH_HALTED;
		else clear_frame_state();
	endfunction

	// length known: mask rule against the role, then key, body or done
	function automatic void length_resolved(input logic [31:0] len);
		total_q = len;
		hcount = 4'd0;
		if (masked_q) begin
			if (client_role) halt_with(RC_PROTO);
			else phase = PH_KEY;
		end else if (!client_role && len != 32'd0) begin
			halt_with(RC_PROTO);
		end else if (len == 32'd0) begin
			finish_empty_frame();
		end else begin
			phase = PH_BODY;
		end
	endfunction

	// predicted effect of one accepted item
	function automatic void deframe_byte(input logic k, input logic [7:0] b);
		logic       is_control;
		logic [7:0] plain;
		logic       closed;
		if (k == KIND_RESTART) begin
			clear_frame_state();
			return;
		end
		is_control = opc_q[3];
		case (phase)
			PH_HEAD1: begin
				fin_q = b[7];
				rsv_q = b[6:4];
				opc_q = b[3:0];
				if (!b[7] && b[3]) halt_with(RC_PROTO);
				else phase = PH_HEAD2;
			end
			PH_HEAD2: begin
				masked_q = b[7];
				short_q = b[6:0];
				ext_q = 64'd0; hcount = 4'd0; total_q = 32'd0; count_q = 32'd0; key_q = 32'd0;
				if (is_control && short_q > MAX_CONTROL_LEN) halt_with(RC_PROTO);
				else if (short_q == LEN16_MARK) phase = PH_LEN16;
				else if (short_q == LEN64_MARK) phase = PH_LEN64;
				else length_resolved({25'd0, short_q});
			end
			PH_LEN16: begin
				ext_q = {48'd0, ext_q[7:0], b};
				hcount = hcount + 4'd1;
				if (hcount == 4'd2) begin
					if (ext_q < MIN_LEN16) halt_with(RC_BADLEN);
					else length_resolved(ext_q[31:0]);
				end
			end
			PH_LEN64: begin
				ext_q = {ext_q[55:0], b};
				hcount = hcount + 4'd1;
				if (hcount == 4'd8) begin
					if (ext_q[63]) halt_with(RC_BADLEN);
					else if (ext_q > {32'd0, len_limit}) halt_with(RC_BADLEN);
					else length_resolved(ext_q[31:0]);
				end
			end
			PH_KEY: begin
				key_q = {key_q[23:0], b};
				hcount = hcount + 4'd1;
				if (hcount == 4'd4) begin
					hcount = 4'd0;
					if (total_q == 32'd0) finish_empty_frame();
					else phase = PH_BODY;
				end
			end
			PH_BODY: begin
				// key bytes rotate from the most significant one
				plain = b;
				if (masked_q) plain = b ^ 8'(key_q >> (5'd24 - {count_q[1:0], 3'b000}));
				count_q = count_q + 32'd1;
				if (count_q < total_q) begin
					post_result(RC_PAYLOAD, plain, 1'b0, 1'b0);
				end else begin
					closed = (opc_q == OPC_CLOSE);
					post_result(RC_PAYLOAD, plain, 1'b1, closed);
					if (closed) phase = PH_HALTED;
					else clear_frame_state();
				end
			end
			default: begin
				wsfd_result_t r;
				phase = PH_HALTED;
				r = '0;
				r.code = RC_REJECT;
				results_due.push_back(r);
			end
		endcase
	endfunction

	// one item transfer, with an optional idle burst in front
	task automatic send_item(input logic k, input logic [7:0] b);
		if (gap_enable && $urandom_range(0, 7) == 0) begin
			item_valid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
		item_valid <= 1'b1;
		kind <= k;
		data_byte <= b;
		do @(posedge clk); while (item_stall);
		deframe_byte(k, b);
		items_sent++;
	endtask

	task automatic restart_decoder();
		send_item(KIND_RESTART, 8'($urandom));
	endtask

	// hold off the sender until every expected result has arrived
	task automatic wait_results_drained();
		item_valid <= 1'b0;
		while (results_due.size() != 0) @(posedge clk);
		repeat (PIPE_SLACK) @(posedge clk);
	endtask

	// both registers in back-to-back transfers, only while idle
	task automatic configure(input logic role, input logic [31:0] limit);
		wait_results_drained();
		cfg_valid <= 1'b1;
		cfg_index <= CFG_ROLE;
		cfg_data <= {31'd0, role};
		do @(posedge clk); while (!cfg_ready);
		client_role = role;
		cfg_index <= CFG_MAX_LEN;
		cfg_data <= limit;
		do @(posedge clk); while (!cfg_ready);
		len_limit = limit;
		cfg_valid <= 1'b0;
	endtask

	// header, extended length and key, then payload while the body is open;
	// stops early once the decoder leaves the header or after cap bytes
	task automatic send_frame(input logic fin, input logic [2:0] rsv, input logic [3:0] opc,
			input logic masked, input length_form_t form, input logic [63:0] len,
			input int unsigned cap);
		logic [7:0]  head[$];
		logic [6:0]  len7;
		int unsigned sent;
		case (form)
			FORM_16: len7 = LEN16_MARK;
			FORM_64: len7 = LEN64_MARK;
			default: len7 = len[6:0];
		endcase
		head.push_back({fin, rsv, opc});
		head.push_back({masked, len7});
		if (form == FORM_16) begin
			head.push_back(len[15:8]);
			head.push_back(len[7:0]);
		end
		if (form == FORM_64)
			for (int i = 7; i >= 0; i--) head.push_back(len[8*i +: 8]);
		if (masked) repeat (4) head.push_back(8'($urandom));
		sent = 0;
		foreach (head[j]) begin
			if (sent == cap) return;
			if (sent != 0 && !(phase inside {PH_HEAD2, PH_LEN16, PH_LEN64, PH_KEY})) return;
			send_item(KIND_DATA, head[j]);
			sent++;
		end
		while (phase == PH_BODY && sent != cap) begin
			send_item(KIND_DATA, 8'($urandom));
			sent++;
		end
	endtask

	// mostly well-formed frames with random content, some broken ones and noise
	task automatic send_random_frame();
		logic         fin;
		logic [2:0]   rsv;
		logic [3:0]   opc;
		logic         masked;
		length_form_t form;
		logic [63:0]  len;
		int unsigned  cap;
		int unsigned  pick;
		if ($urandom_range(0, 99) < 4) begin
			repeat ($urandom_range(1, 6)) send_item(KIND_DATA, 8'($urandom));
			restart_decoder();
			return;
		end
		case ($urandom_range(0, 9))
			0, 1, 2: opc = OPC_TEXT;
			3, 4:    opc = OPC_BINARY;
			5:       opc = OPC_CONT;
			6:       opc = OPC_PING;
			7:       opc = OPC_PONG;
			8:       opc = OPC_CLOSE;
			default: opc = 4'($urandom);
		endcase
		fin = opc[3] ? ($urandom_range(0, 19) != 0) : 1'($urandom);
		rsv = ($urandom_range(0, 4) == 0) ? 3'($urandom) : 3'd0;
		masked = ($urandom_range(0, 14) == 0) ? client_role : !client_role;
		pick = $urandom_range(0, 99);
		if (pick < 75) begin
			form = FORM_SHORT;
			len = ($urandom_range(0, 9) == 0) ? 64'($urandom_range(100, 125)) :
				64'($urandom_range(0, 12));
		end else if (pick < 82) begin
			form = FORM_16;
			len = ($urandom_range(0, 3) == 0) ? 64'($urandom_range(0, 125)) :
				64'($urandom_range(126, 140));
		end else begin
			form = FORM_64;
			case ($urandom_range(0, 5))
				0:       len = {1'b1, 31'($urandom), 32'($urandom)};
				1:       len = {32'd0, len_limit} + 64'd1 + 64'($urandom_range(0, 3));
				2:       len = {32'($urandom) | 32'd1, 32'($urandom)};
				default: len = 64'($urandom_range(0, 20));
			endcase
		end
		cap = ($urandom_range(0, 15) == 0) ? $urandom_range(1, 8) : NO_CAP;
		send_frame(fin, rsv, opc, masked, form, len, cap);
		// recover from errors, close frames and cut frames
		if (cap != NO_CAP || phase != PH_HEAD1) begin
			if (phase == PH_HALTED)
				repeat ($urandom_range(0, 2)) send_item(KIND_DATA, 8'($urandom));
			restart_decoder();
		end else if ($urandom_range(0, 49) == 0) begin
			wait_results_drained();
		end
	endtask

	// server role: mask rule, control frame rules, bad extended lengths
	task automatic test_server_rules();
		configure(1'b0, MAX_LEN_RESET);
		send_frame(1'b1, 3'd0, OPC_TEXT, 1'b1, FORM_SHORT, 3, NO_CAP);
		send_frame(1'b1, 3'd0, OPC_PING, 1'b1, FORM_SHORT, 0, NO_CAP);
		send_frame(1'b1, 3'd0, OPC_BINARY, 1'b0, FORM_SHORT, 0, NO_CAP);
		send_frame(1'b1, 3'd0, OPC_TEXT, 1'b0, FORM_SHORT, 4, NO_CAP);
		send_item(KIND_DATA, 8'h00);
		restart_decoder();
		send_frame(1'b0, 3'd0, OPC_CLOSE, 1'b1, FORM_SHORT, 0, NO_CAP);
		restart_decoder();
		// all-ones header bytes: control frame with the 64-bit length mark
		send_frame(1'b1, 3'd7, 4'hF, 1'b1, FORM_64, 0, NO_CAP);
		send_item(KIND_DATA, 8'hFF);
		restart_decoder();
		send_frame(1'b1, 3'd0, OPC_PONG, 1'b1, FORM_16, 130, NO_CAP);
		restart_decoder();
		send_frame(1'b1, 3'd0, OPC_BINARY, 1'b1, FORM_16, 125, NO_CAP);
		restart_decoder();
		send_frame(1'b1, 3'd0, OPC_BINARY, 1'b1, FORM_64, {1'b1, 63'd0}, NO_CAP);
		restart_decoder();
		send_frame(1'b1, 3'd0, OPC_BINARY, 1'b1, FORM_64, {32'd0, MAX_LEN_RESET} + 64'd1,
			NO_CAP);
		restart_decoder();
		send_frame(1'b1, 3'd0, OPC_TEXT, 1'b1, FORM_SHORT, 5, 4);
		restart_decoder();
	endtask

	// client role: unmasked frames, close frames halting the decoder
	task automatic test_client_and_close();
		configure(1'b1, MAX_LEN_RESET);
		send_frame(1'b1, 3'd5, OPC_TEXT, 1'b0, FORM_SHORT, 2, NO_CAP);
		send_frame(1'b1, 3'd0, OPC_TEXT, 1'b1, FORM_SHORT, 2, NO_CAP);
		restart_decoder();
		send_frame(1'b1, 3'd0, OPC_CLOSE, 1'b0, FORM_SHORT, 0, NO_CAP);
		send_item(KIND_DATA, 8'h5A);
		restart_decoder();
		send_frame(1'b1, 3'd0, OPC_CLOSE, 1'b0, FORM_SHORT, 2, NO_CAP);
		send_item(KIND_DATA, 8'hA5);
		restart_decoder();
	endtask

	// 64-bit length form against the limit at its extremes
	task automatic test_length_limits();
		configure(1'b1, 32'd0);
		send_frame(1'b1, 3'd0, OPC_BINARY, 1'b0, FORM_64, 0, NO_CAP);
		send_frame(1'b1, 3'd0, OPC_BINARY, 1'b0, FORM_64, 1, NO_CAP);
		restart_decoder();
		configure(1'b1, 32'hFFFF_FFFF);
		send_frame(1'b1, 3'd0, OPC_BINARY, 1'b0, FORM_64, 64'h1_0000_0000, NO_CAP);
		restart_decoder();
		send_frame(1'b0, 3'd0, OPC_CONT, 1'b0, FORM_64, 3, NO_CAP);
	endtask

	// random frames over several register settings, the last one without idling
	task automatic test_random_traffic();
		logic [31:0] limits[5];
		logic        roles[5];
		int unsigned budget[5];
		int unsigned stop_at;
		roles = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0};
		limits = '{MAX_LEN_RESET, 32'($urandom_range(0, 40)), 32'hFFFF_FFFF, 32'd0, 32'd20};
		budget = '{400, 400, 400, 350, 300};
		for (int p = 0; p < 5; p++) begin
			configure(roles[p], limits[p]);
			gap_enable = (p != 4);
			stall_enable = (p != 4);
			stop_at = items_sent + budget[p];
			while (items_sent < stop_at) send_random_frame();
		end
	endtask

	// result transfers checked against the oldest expectation; random stalls
	always @(posedge clk) begin : result_monitor
		wsfd_result_t got;
		wsfd_result_t want;
		if (arst_n && result_valid && !result_stall) begin
			got = {result_code, payload_byte, last_of_frame, fin_bit, rsv_bits,
				frame_opcode, frame_length, connection_closed};
			if (results_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: code %0d byte %02h len %0d",
						got.code, got.payload_byte, got.frame_length);
			end else begin
				want = results_due.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("mismatch (expected/actual): code %0d/%0d byte %02h/%02h",
							want.code, got.code, want.payload_byte, got.payload_byte);
						$display("  last %0b/%0b fin %0b/%0b rsv %0d/%0d opcode %0h/%0h",
							want.last_of_frame, got.last_of_frame, want.fin_bit, got.fin_bit,
							want.rsv_bits, got.rsv_bits, want.frame_opcode, got.frame_opcode);
						$display("  length %0d/%0d closed %0b/%0b", want.frame_length,
							got.frame_length, want.connection_closed, got.connection_closed);
					end
				end
			end
		end
		if (stall_left == 0 && stall_enable && $urandom_range(0, 7) == 0)
			stall_left = $urandom_range(1, 10);
		if (stall_left != 0) begin
			result_stall <= 1'b1;
			stall_left--;
		end else begin
			result_stall <= 1'b0;
		end
	end

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		test_server_rules();
		test_client_and_close();
		test_length_limits();
		test_random_traffic();
		wait_results_drained();
		if (mismatches == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	// run limit
	initial begin
		#5_000_000;
		$display("DONE: errors detected");
		$finish;
	end

endmodule

### sim.f
+incdir+design
design/wsfd_pkg.sv
design/wsfd_parse_core.sv
design/websocket_frame_deframer_top.sv
tb/sv/testbench.sv
